/* rtl/skt_pkg.sv */
// shared types, codes and field widths for the sorted key table
// no dependencies
package skt_pkg;

	localparam int DEF_CAPACITY = 64;

	localparam int OP_W     = 2;
	localparam int KEY_W    = 32;
	localparam int PAY_W    = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic cmp;
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

/* rtl/skt_cell.sv */
// one slot of the sorted chain: key, payload and the registered compare flag
// depends on skt_pkg
module skt_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic                        clk,
	input  skt_pkg::cell_ctl_t          ctl,
	input  logic [CNT_W-1:0]            count,
	input  logic signed [skt_pkg::KEY_W-1:0] req_key,
	input  logic [skt_pkg::PAY_W-1:0]   req_pay,
	input  logic signed [skt_pkg::KEY_W-1:0] left_key,
	input  logic [skt_pkg::PAY_W-1:0]   left_pay,
	input  logic                        left_lt,
	input  logic signed [skt_pkg::KEY_W-1:0] right_key,
	input  logic [skt_pkg::PAY_W-1:0]   right_pay,
	output logic signed [skt_pkg::KEY_W-1:0] key,
	output logic [skt_pkg::PAY_W-1:0]   pay,
	output logic                        lt,
	output logic                        eq
);
	import skt_pkg::*;

	localparam logic [CNT_W-1:0] IDX_V = CNT_W'(IDX);

	logic signed [KEY_W-1:0] key_q;
	logic [PAY_W-1:0]        pay_q;
	logic                    lt_s1;
	logic                    held;
	logic                    lt_c;

	// a slot holds a live entry only below the fill count
	assign held = IDX_V < count;
	assign lt_c = held && (key_q < req_key);
	assign eq   = held && (key_q == req_key);

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			lt_s1 <= lt_c;
		end
		if (ctl.ins && !lt_s1) begin
			// first slot at or past the key takes the new word, the rest move up
			if (left_lt) begin
				key_q <= req_key;
				pay_q <= req_pay;
			end else begin
				key_q <= left_key;
				pay_q <= left_pay;
			end
		end
		if (ctl.rem && !lt_s1) begin
			key_q <= right_key;
			pay_q <= right_pay;
		end
	end

	assign key = key_q;
	assign pay = pay_q;
	assign lt  = lt_s1;

endmodule

/* rtl/sorted_key_table.sv */
// sorted key table: top level, request sequencer and the chain of slots
// depends on skt_pkg and skt_cell
//
// channel   direction  handshake                    fields
// request   in         start && !busy               opcode, entry_key, entry_payload
// result    out        done, one cycle, no stall    status, found_payload, entry_count
//
// each request runs a compare state, which checks the key against every slot, and
// then a shift state, which shifts the chain and drops the result; a new request
// can be taken in the shift state; the result strobe follows in the next cycle.
// reset clears the fill count and the sequencer; slot contents are left as they are.
// the result side cannot stall, so busy only reflects the compare cycle.
module sorted_key_table #(
	parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [skt_pkg::OP_W-1:0]          opcode,
	input  logic signed [skt_pkg::KEY_W-1:0]  entry_key,
	input  logic [skt_pkg::PAY_W-1:0]         entry_payload,
	output logic                              done,
	output logic [skt_pkg::STATUS_W-1:0]      status,
	output logic [skt_pkg::PAY_W-1:0]         found_payload,
	output logic [skt_pkg::COUNT_W-1:0]       entry_count
);
	import skt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_ACT
	} state_t;

	state_t                  state_q;
	logic [OP_W-1:0]         op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [PAY_W-1:0]        pay_q;
	logic [CNT_W-1:0]        count_q;
	logic                    hit_s1;
	logic [PAY_W-1:0]        hit_pay_s1;
	logic                    done_q;
	logic [STATUS_W-1:0]     status_q;
	logic [PAY_W-1:0]        found_q;
	logic [COUNT_W-1:0]      entry_count_q;

	logic signed [KEY_W-1:0] cell_key [CAPACITY];
	logic [PAY_W-1:0]        cell_pay [CAPACITY];
	logic [CAPACITY-1:0]     cell_lt;
	logic [CAPACITY-1:0]     cell_eq;

	cell_ctl_t               ctl;
	logic                    accept;
	logic                    full;
	logic                    do_ins;
	logic                    do_rem;
	logic                    hit_c;
	logic [PAY_W-1:0]        hit_pay_c;
	logic [STATUS_W-1:0]     status_c;
	logic [PAY_W-1:0]        found_c;
	logic [CNT_W-1:0]        count_c;

	assign busy   = (state_q == S_CMP);
	assign accept = start && !busy;
	assign full   = (count_q == CAP_V);
	assign do_ins = (state_q == S_ACT) && (op_q == OP_INSERT) && !hit_s1 && !full;
	assign do_rem = (state_q == S_ACT) && (op_q == OP_REMOVE) && hit_s1;

	assign ctl.cmp = (state_q == S_CMP);
	assign ctl.ins = do_ins;
	assign ctl.rem = do_rem;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [KEY_W-1:0] lk;
		logic [PAY_W-1:0]        lp;
		logic                    llt;
		logic signed [KEY_W-1:0] rk;
		logic [PAY_W-1:0]        rp;

		// slot zero sees an always-smaller neighbour, the last slot pulls in don't-care data
		if (i == 0) begin : g_first
			assign lk  = key_q;
			assign lp  = pay_q;
			assign llt = 1'b1;
		end else begin : g_mid_l
			assign lk  = cell_key[i-1];
			assign lp  = cell_pay[i-1];
			assign llt = cell_lt[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rk = key_q;
			assign rp = pay_q;
		end else begin : g_mid_r
			assign rk = cell_key[i+1];
			assign rp = cell_pay[i+1];
		end

		skt_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.req_key   (key_q),
			.req_pay   (pay_q),
			.left_key  (lk),
			.left_pay  (lp),
			.left_lt   (llt),
			.right_key (rk),
			.right_pay (rp),
			.key       (cell_key[i]),
			.pay       (cell_pay[i]),
			.lt        (cell_lt[i]),
			.eq        (cell_eq[i])
		);
	end

	// keys are unique, so at most one slot matches and an and-or gathers its payload
	always_comb begin
		hit_c     = 1'b0;
		hit_pay_c = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_c     = hit_c | cell_eq[i];
			hit_pay_c = hit_pay_c | (cell_pay[i] & {PAY_W{cell_eq[i]}});
		end
	end

	always_comb begin
		status_c = ST_MISSING;
		found_c  = '0;
		count_c  = count_q;
		case (op_q)
			OP_INSERT: begin
				if (hit_s1) begin
					status_c = ST_DUP;
				end else if (full) begin
					status_c = ST_FULL;
				end else begin
					status_c = ST_OK;
					count_c  = count_q + 1'b1;
				end
			end
			OP_FIND: begin
				if (hit_s1) begin
					status_c = ST_OK;
					found_c  = hit_pay_s1;
				end
			end
			OP_REMOVE: begin
				if (hit_s1) begin
					status_c = ST_OK;
					found_c  = hit_pay_s1;
					count_c  = count_q - 1'b1;
				end
			end
			default: begin
				status_c = ST_MISSING;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_FIND;
			key_q         <= '0;
			pay_q         <= '0;
			count_q       <= '0;
			hit_s1        <= 1'b0;
			hit_pay_s1    <= '0;
			done_q        <= 1'b0;
			status_q      <= ST_OK;
			found_q       <= '0;
			entry_count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				op_q  <= opcode;
				key_q <= entry_key;
				pay_q <= entry_payload;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					hit_s1     <= hit_c;
					hit_pay_s1 <= hit_pay_c;
					state_q    <= S_ACT;
				end
				S_ACT: begin
					count_q       <= count_c;
					done_q        <= 1'b1;
					status_q      <= status_c;
					found_q       <= found_c;
					entry_count_q <= COUNT_W'(count_c);
					state_q       <= accept ? S_CMP : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign found_payload = found_q;
	assign entry_count   = entry_count_q;

	a_cmp_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("compare phase held longer than one cycle");

	a_done_after_act: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_ACT))
		else $error("result strobe without a shift cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_V)
		else $error("fill count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1)
		|| (count_q + 1'b1 == $past(count_q)))
		else $error("fill count moved by more than one");

	a_shift_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.ins && ctl.rem) && !(ctl.cmp && (ctl.ins || ctl.rem)))
		else $error("conflicting chain commands");

endmodule
